### rtl/vtbc_pkg.sv
// ----------------------------------------------------------------------------
// vtbc_pkg
// Shared types and constants of the vertex transform and back-face cull block
// ----------------------------------------------------------------------------
package vtbc_pkg;

  // divider operand widths: clip * 2^14 and clip w
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 34;

  // field widths
  localparam int SLOT_W  = 10;
  localparam int COORD_W = 16;
  localparam int ENTRY_W = 3 * COORD_W;
  localparam int CFG_IDX_W = 3;

  // input item kinds
  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ROW0,
    CFG_MATRIX_ROW1,
    CFG_MATRIX_ROW2,
    CFG_MATRIX_ROW3,
    CFG_VIEWPORT_ORIGIN,
    CFG_VIEWPORT_SIZE,
    CFG_CULL_ENABLE
  } vtbc_cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_END,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_VP_X,
    ST_VP_Y,
    ST_VP_END,
    ST_WRITE,
    ST_READ,
    ST_READ_END,
    ST_CULL_A,
    ST_CULL_B,
    ST_CULL_END,
    ST_EMIT
  } vtbc_state_t;

endpackage

### rtl/vtbc_ram.sv
// ----------------------------------------------------------------------------
// vtbc_ram
// Generic simple dual-port RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module vtbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/vtbc_div.sv
// ----------------------------------------------------------------------------
// vtbc_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module vtbc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [vtbc_pkg::DIV_NUM_W-1:0] num,
  input  logic signed [vtbc_pkg::DIV_DEN_W-1:0] den,
  output logic                                done,
  output logic signed [vtbc_pkg::DIV_NUM_W-1:0] quo
);
  import vtbc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitudes and shifting quotient
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
      quo_r <= num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
      den_r <= den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

### rtl/vertex_transform_and_backface_cull.sv
// ----------------------------------------------------------------------------
// vertex_transform_and_backface_cull
// Fixed-point vertex transform, perspective divide, viewport map and culling
// ----------------------------------------------------------------------------
// A vertex beat runs the 4x4 matrix product on one shared multiplier, then
// three passes through the bit-serial divider (x, y and z by w), the viewport
// map and a write of both vertex memories. A triangle beat makes three reads
// of the one read port of each memory and, with culling on, two cross
// product multiplies, after which a back-facing triangle is dropped. One
// item is worked on at a time; in_stall is high while it runs, and a
// finished triangle waits in the output register so the next item can be
// taken while out_stall holds it. Vertex memories have no reset; triangles
// must only name slots already written.
module vertex_transform_and_backface_cull #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [vtbc_pkg::SLOT_W-1:0]           in_vertex_slot,
  input  logic signed [vtbc_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [vtbc_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [vtbc_pkg::COORD_W-1:0]   in_pos_z,
  input  logic [vtbc_pkg::SLOT_W-1:0]           in_corner_a,
  input  logic [vtbc_pkg::SLOT_W-1:0]           in_corner_b,
  input  logic [vtbc_pkg::SLOT_W-1:0]           in_corner_c,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_ax,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_ay,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_depth_a,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_bx,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_by,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_depth_b,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_cx,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_screen_cy,
  output logic signed [vtbc_pkg::COORD_W-1:0]   out_depth_c,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vtbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [63:0]                           cfg_data
);
  import vtbc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [MUL_P_W-1:0] v);
    logic signed [15:0] r;
    if (v > MUL_P_W'(32767)) r = 16'sh7fff;
    else if (v < -MUL_P_W'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // clamp to 32 bits signed
  function automatic logic signed [31:0] clamp32(input logic signed [DIV_NUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > DIV_NUM_W'(33'sh07fffffff)) r = 32'sh7fffffff;
    else if (v < -DIV_NUM_W'(33'sh080000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration registers
  logic [63:0] mat_r [4];
  logic [31:0] vp_org_r;
  logic [31:0] vp_size_r;
  logic        cull_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0]  <= 64'h0000_0000_0000_1000;
      mat_r[1]  <= 64'h0000_0000_1000_0000;
      mat_r[2]  <= 64'h0000_1000_0000_0000;
      mat_r[3]  <= 64'h1000_0000_0000_0000;
      vp_org_r  <= '0;
      vp_size_r <= 32'h01e0_0280;
      cull_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATRIX_ROW0, CFG_MATRIX_ROW1, CFG_MATRIX_ROW2, CFG_MATRIX_ROW3:
          mat_r[cfg_index[1:0]] <= cfg_data;
        CFG_VIEWPORT_ORIGIN: vp_org_r  <= cfg_data[31:0];
        CFG_VIEWPORT_SIZE:   vp_size_r <= cfg_data[31:0];
        CFG_CULL_ENABLE:     cull_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  vtbc_state_t state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic        in_acc;
  logic        vert_ok;
  logic        out_free;
  logic        back_face;
  logic        div_done;

  assign in_acc   = in_valid && !in_stall;
  assign vert_ok  = (32'(in_vertex_slot) < 32'(MAX_VERTICES));
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_TRIANGLE) state_nxt = ST_READ;
          else if (vert_ok) state_nxt = ST_MAC;
        end
      end
      ST_MAC:      if (cnt_r == 4'd15) state_nxt = ST_MAC_END;
      ST_MAC_END:  state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = (cnt_r == 4'd2) ? ST_VP_X : ST_DIV_GO;
      end
      ST_VP_X:     state_nxt = ST_VP_Y;
      ST_VP_Y:     state_nxt = ST_VP_END;
      ST_VP_END:   state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_IDLE;
      ST_READ:     if (cnt_r == 4'd2) state_nxt = ST_READ_END;
      ST_READ_END: state_nxt = cull_r ? ST_CULL_A : ST_EMIT;
      ST_CULL_A:   state_nxt = ST_CULL_B;
      ST_CULL_B:   state_nxt = ST_CULL_END;
      ST_CULL_END: state_nxt = back_face ? ST_IDLE : ST_EMIT;
      ST_EMIT:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_MAC, ST_READ: cnt_r <= cnt_r + 1'b1;
        ST_DIV_GO:       cnt_r <= cnt_r;
        ST_DIV_WAIT:     if (div_done) cnt_r <= cnt_r + 1'b1;
        default:         cnt_r <= '0;
      endcase
    end
  end

  // item registers
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [SLOT_W-1:0]         corner_r [3];
  logic [2:0]                rng_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r        <= in_pos_x;
      py_r        <= in_pos_y;
      pz_r        <= in_pos_z;
      slot_r      <= in_vertex_slot;
      corner_r[0] <= in_corner_a;
      corner_r[1] <= in_corner_b;
      corner_r[2] <= in_corner_c;
      rng_r[0]    <= (32'(in_corner_a) < 32'(MAX_VERTICES));
      rng_r[1]    <= (32'(in_corner_b) < 32'(MAX_VERTICES));
      rng_r[2]    <= (32'(in_corner_c) < 32'(MAX_VERTICES));
    end
  end

  // datapath registers
  logic signed [MUL_A_W-1:0] clip_r [4];
  logic signed [31:0]        ndcx_r, ndcy_r;
  logic signed [15:0]        depth_r, sx_r, sy_r;
  logic [ENTRY_W-1:0]        obj_r [3];
  logic [ENTRY_W-1:0]        scr_r [3];
  logic signed [34:0]        cross_r;
  logic                      acc_en_r, rd_en_r;
  logic [3:0]                acc_idx_r;
  logic [1:0]                rd_idx_r;

  // control outputs
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p_r;
  logic                      div_start;
  logic                      mem_we;
  logic [AW-1:0]             mem_raddr;
  logic [15:0]               vp_off;
  logic signed [16:0]        e0x, e0y, e1x, e1y;
  logic signed [COORD_W-1:0] p_sel;
  logic [1:0]                mrow, mcol;

  assign mrow = cnt_r[3:2];
  assign mcol = cnt_r[1:0];

  // edges of the object-space triangle
  always_comb begin
    e0x = 17'($signed(obj_r[1][15:0]))  - 17'($signed(obj_r[0][15:0]));
    e0y = 17'($signed(obj_r[1][31:16])) - 17'($signed(obj_r[0][31:16]));
    e1x = 17'($signed(obj_r[2][15:0]))  - 17'($signed(obj_r[0][15:0]));
    e1y = 17'($signed(obj_r[2][31:16])) - 17'($signed(obj_r[0][31:16]));
  end

  always_comb begin
    case (mcol)
      2'd0:    p_sel = px_r;
      2'd1:    p_sel = py_r;
      2'd2:    p_sel = pz_r;
      default: p_sel = 16'sd256;
    endcase
  end

  // operand selection and strobes
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = AW'(corner_r[cnt_r[1:0]]);
    vp_off    = (state_r == ST_VP_Y) ? vp_org_r[15:0] : vp_org_r[31:16];
    case (state_r)
      ST_MAC: begin
        mul_a = MUL_A_W'($signed(mat_r[mrow][16*mcol +: 16]));
        mul_b = MUL_B_W'(p_sel);
      end
      ST_VP_X: begin
        mul_a = MUL_A_W'(ndcx_r) + MUL_A_W'(16384);
        mul_b = $signed({1'b0, vp_size_r[15:0]});
      end
      ST_VP_Y: begin
        mul_a = MUL_A_W'(16384) - MUL_A_W'(ndcy_r);
        mul_b = $signed({1'b0, vp_size_r[31:16]});
      end
      ST_CULL_A: begin
        mul_a = MUL_A_W'(e0x);
        mul_b = e1y;
      end
      ST_CULL_B: begin
        mul_a = MUL_A_W'(e0y);
        mul_b = e1x;
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_WRITE:  mem_we    = 1'b1;
      default: ;
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // divider for the perspective divide; w of zero divides by 2^20
  logic signed [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_DEN_W-1:0] div_den;
  logic signed [DIV_NUM_W-1:0] div_quo;

  assign div_num = $signed({clip_r[cnt_r[1:0]], 14'b0});
  assign div_den = (clip_r[3] != '0) ? clip_r[3] : DIV_DEN_W'(34'sd1 <<< 20);

  vtbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // vertex memories
  logic [ENTRY_W-1:0] obj_rdata, scr_rdata;

  vtbc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_obj_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(slot_r)),
    .wdata ({pz_r, py_r, px_r}),
    .raddr (mem_raddr),
    .rdata (obj_rdata)
  );

  vtbc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_scr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(slot_r)),
    .wdata ({depth_r, sy_r, sx_r}),
    .raddr (mem_raddr),
    .rdata (scr_rdata)
  );

  // pipeline tags for multiplier and memory returns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      rd_en_r  <= 1'b0;
    end else begin
      acc_en_r <= (state_r == ST_MAC);
      rd_en_r  <= (state_r == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    acc_idx_r <= cnt_r;
    rd_idx_r  <= cnt_r[1:0];
  end

  // viewport sum
  logic signed [MUL_P_W-1:0] vp_sum;
  logic signed [34:0]        cross_diff;

  assign vp_sum     = (mul_p_r >>> 11) + $signed({(MUL_P_W-20)'(0), vp_off, 4'b0});
  assign cross_diff = cross_r - mul_p_r[34:0];
  assign back_face  = (cross_diff > 35'sd0);

  // datapath updates
  always_ff @(posedge clk) begin
    if (acc_en_r) begin
      if (acc_idx_r[1:0] == 2'd0) clip_r[acc_idx_r[3:2]] <= mul_p_r[MUL_A_W-1:0];
      else clip_r[acc_idx_r[3:2]] <= clip_r[acc_idx_r[3:2]] + mul_p_r[MUL_A_W-1:0];
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      case (cnt_r[1:0])
        2'd0:    ndcx_r  <= clamp32(div_quo);
        2'd1:    ndcy_r  <= clamp32(div_quo);
        default: depth_r <= sat16(MUL_P_W'(div_quo));
      endcase
    end
    if (state_r == ST_VP_Y) sx_r <= sat16(vp_sum);
    if (state_r == ST_VP_END) sy_r <= sat16(vp_sum);
    if (rd_en_r) begin
      obj_r[rd_idx_r] <= rng_r[rd_idx_r] ? obj_rdata : '0;
      scr_r[rd_idx_r] <= rng_r[rd_idx_r] ? scr_rdata : '0;
    end
    if (state_r == ST_CULL_B) cross_r <= mul_p_r[34:0];
  end

  assign in_stall = (state_r != ST_IDLE);

  // output register
  logic load_out;
  assign load_out = (state_r == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_screen_ax <= scr_r[0][15:0];
      out_screen_ay <= scr_r[0][31:16];
      out_depth_a   <= scr_r[0][47:32];
      out_screen_bx <= scr_r[1][15:0];
      out_screen_by <= scr_r[1][31:16];
      out_depth_b   <= scr_r[1][47:32];
      out_screen_cx <= scr_r[2][15:0];
      out_screen_cy <= scr_r[2][31:16];
      out_depth_c   <= scr_r[2][47:32];
    end
  end

endmodule
